// ===== design/mse_pkg.sv =====
// mse_pkg: shared widths, action codes and write-back record for the execute unit
// no dependencies; imported by mips_subset_execute_unit and mse_checker
`default_nettype none

package mse_pkg;

	localparam int DataW       = 32;
	localparam int RegIdxW     = 5;
	localparam int ActW        = 4;
	localparam int MemIdxOutW  = 10;
	localparam int RegCount    = 32;
	localparam int MemWordsDef = 1024;

	localparam logic [RegIdxW-1:0] LINK_REG   = 5'd31;
	localparam logic [DataW-1:0]   WORD_BYTES = 32'd4;

	localparam logic [ActW-1:0] ACT_ADD = 4'd0;
	localparam logic [ActW-1:0] ACT_SUB = 4'd1;
	localparam logic [ActW-1:0] ACT_MUL = 4'd2;
	localparam logic [ActW-1:0] ACT_AND = 4'd3;
	localparam logic [ActW-1:0] ACT_OR  = 4'd4;
	localparam logic [ActW-1:0] ACT_SLT = 4'd5;
	localparam logic [ActW-1:0] ACT_LW  = 4'd6;
	localparam logic [ActW-1:0] ACT_SW  = 4'd7;
	localparam logic [ActW-1:0] ACT_LI  = 4'd8;
	localparam logic [ActW-1:0] ACT_BEQ = 4'd9;
	localparam logic [ActW-1:0] ACT_BNE = 4'd10;
	localparam logic [ActW-1:0] ACT_J   = 4'd11;
	localparam logic [ActW-1:0] ACT_JAL = 4'd12;
	localparam logic [ActW-1:0] ACT_JR  = 4'd13;

	typedef struct packed {
		logic               wr;
		logic [RegIdxW-1:0] idx;
		logic [DataW-1:0]   val;
	} wb_t;

endpackage

`default_nettype wire

// ===== design/mips_subset_execute_unit.sv =====
// pipeline: input transfer to result valid through read, execute and result register
// throughput: one instruction per cycle unless the output stalls; register file
// forwarding from write-back and the previous write; dependent instructions never stall
// reset: pc and register valid bits cleared at once; data memory then cleared by a
// pass over all MEM_WORDS words during which in_ready is low
// memories: 32 x 32 register file (1 write, 2 reads), MEM_WORDS x 32 data memory
`default_nettype none

module mips_subset_execute_unit #(
	parameter int MEM_WORDS = mse_pkg::MemWordsDef
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [mse_pkg::ActW-1:0]         action,
	input  wire logic [mse_pkg::RegIdxW-1:0]      reg_d,
	input  wire logic [mse_pkg::RegIdxW-1:0]      reg_s,
	input  wire logic [mse_pkg::RegIdxW-1:0]      reg_t,
	input  wire logic signed [mse_pkg::DataW-1:0] immediate,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic signed [mse_pkg::DataW-1:0]      next_pc,
	output logic                                  branch_taken,
	output logic                                  reg_written,
	output logic [mse_pkg::RegIdxW-1:0]           written_index,
	output logic signed [mse_pkg::DataW-1:0]      written_value,
	output logic                                  mem_written,
	output logic [mse_pkg::MemIdxOutW-1:0]        mem_word_index,
	output logic                                  address_fault
);
	import mse_pkg::*;

	localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

	// memories
	logic [DataW-1:0] rf_mem [RegCount];
	logic [RegCount-1:0] rf_vld_q;
	logic [DataW-1:0] dmem [MEM_WORDS];

	// control
	logic clr_q;
	logic [AW-1:0] clr_cnt_q;
	logic adv, accept;
	logic [DataW-1:0] pc_q;
	wb_t wb_q, s2_wb;

	// stage 1
	logic v_s1;
	logic [ActW-1:0] act_s1;
	logic [RegIdxW-1:0] rd_s1, ra_s1, rb_s1;
	logic [DataW-1:0] imm_s1, rfa_s1, rfb_s1;
	logic va_s1, vb_s1;

	// stage 2
	logic v_s2, wr_s2, is_mul_s2, is_lw_s2, taken_s2, mwr_s2, fault_s2;
	logic [RegIdxW-1:0] widx_s2;
	logic [DataW-1:0] val_s2, prod_s2, pc_s2, lrd_s2, s2_val;
	logic [AW-1:0] midx_s2;

	// output register
	logic out_valid_q, taken_q, wr_q, mwr_q, fault_q;
	logic [RegIdxW-1:0] widx_q;
	logic [DataW-1:0] wval_q, pc_out_q;
	logic [MemIdxOutW-1:0] midx_q;
	logic [31:0] midx_ext;

	// execute signals
	logic [DataW-1:0] opa, opb, addr, pc_n, val_n, prod_n;
	logic near_zero_neg, in_range;
	logic [29:0] idx30;
	logic [AW-1:0] midx_n;
	logic wr_n, is_mul_n, is_lw_n, taken_n, mwr_n, fault_n, mem_acc_n;
	logic [RegIdxW-1:0] widx_n;

	assign adv      = !(out_valid_q && !out_ready && v_s2);
	assign in_ready = adv && !clr_q;
	assign accept   = in_valid && in_ready;

	// data memory clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			if (clr_cnt_q == AW'(MEM_WORDS - 1)) begin
				clr_q <= 1'b0;
			end
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	// register file read on transfer, write from stage 2
	always_ff @(posedge clk) begin
		if (accept) begin
			rfa_s1 <= rf_mem[reg_s];
			rfb_s1 <= rf_mem[(action == ACT_SW) ? reg_d : reg_t];
			va_s1  <= rf_vld_q[reg_s];
			vb_s1  <= rf_vld_q[(action == ACT_SW) ? reg_d : reg_t];
		end
		if (adv && s2_wb.wr) begin
			rf_mem[s2_wb.idx] <= s2_wb.val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q <= '0;
			wb_q     <= '0;
		end else if (adv) begin
			wb_q <= s2_wb;
			if (s2_wb.wr) begin
				rf_vld_q[s2_wb.idx] <= 1'b1;
			end
		end
	end

	// stage 1 capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1 <= action;
			rd_s1  <= reg_d;
			ra_s1  <= reg_s;
			rb_s1  <= (action == ACT_SW) ? reg_d : reg_t;
			imm_s1 <= immediate;
		end
	end

	// forwarding
	always_comb begin
		s2_val = is_lw_s2 ? lrd_s2 : (is_mul_s2 ? prod_s2 : val_s2);
		s2_wb  = '{wr: v_s2 && wr_s2, idx: widx_s2, val: s2_val};
		if (s2_wb.wr && s2_wb.idx == ra_s1) begin
			opa = s2_wb.val;
		end else if (wb_q.wr && wb_q.idx == ra_s1) begin
			opa = wb_q.val;
		end else begin
			opa = va_s1 ? rfa_s1 : '0;
		end
		if (s2_wb.wr && s2_wb.idx == rb_s1) begin
			opb = s2_wb.val;
		end else if (wb_q.wr && wb_q.idx == rb_s1) begin
			opb = wb_q.val;
		end else begin
			opb = vb_s1 ? rfb_s1 : '0;
		end
	end

	// execute
	always_comb begin
		addr          = opa + imm_s1;
		near_zero_neg = addr[31] && (&addr[31:2]) && (|addr[1:0]);
		idx30         = near_zero_neg ? 30'd0 : addr[31:2];
		in_range      = addr[31] ? near_zero_neg : (addr[31:2] < 30'(MEM_WORDS));
		midx_n        = idx30[AW-1:0];
		prod_n        = opa * opb;

		wr_n      = 1'b0;
		widx_n    = rd_s1;
		val_n     = '0;
		is_mul_n  = 1'b0;
		is_lw_n   = 1'b0;
		taken_n   = 1'b0;
		mwr_n     = 1'b0;
		fault_n   = 1'b0;
		mem_acc_n = 1'b0;
		pc_n      = pc_q;

		unique case (act_s1) inside
			ACT_ADD: begin
				wr_n  = 1'b1;
				val_n = opa + opb;
			end
			ACT_SUB: begin
				wr_n  = 1'b1;
				val_n = opa - opb;
			end
			ACT_MUL: begin
				wr_n     = 1'b1;
				is_mul_n = 1'b1;
			end
			ACT_AND: begin
				wr_n  = 1'b1;
				val_n = opa & opb;
			end
			ACT_OR: begin
				wr_n  = 1'b1;
				val_n = opa | opb;
			end
			ACT_SLT: begin
				wr_n  = 1'b1;
				val_n = ($signed(opa) < $signed(opb)) ? 32'd1 : 32'd0;
			end
			ACT_LW, ACT_SW: begin
				if (!in_range) begin
					fault_n = 1'b1;
				end else begin
					mem_acc_n = 1'b1;
					if (act_s1 == ACT_LW) begin
						wr_n    = 1'b1;
						is_lw_n = 1'b1;
					end else begin
						mwr_n = 1'b1;
					end
				end
			end
			ACT_LI: begin
				wr_n  = 1'b1;
				val_n = imm_s1;
			end
			ACT_BEQ, ACT_BNE: begin
				if ((opa == opb) == (act_s1 == ACT_BEQ)) begin
					taken_n = 1'b1;
					pc_n    = pc_q + {imm_s1[29:0], 2'b00};
				end
			end
			ACT_J: begin
				taken_n = 1'b1;
				pc_n    = {imm_s1[29:0], 2'b00};
			end
			ACT_JAL: begin
				taken_n = 1'b1;
				wr_n    = 1'b1;
				widx_n  = LINK_REG;
				val_n   = pc_q + WORD_BYTES;
				pc_n    = {imm_s1[29:0], 2'b00};
			end
			ACT_JR: begin
				taken_n = 1'b1;
				pc_n    = opa;
			end
			default: begin
				wr_n = 1'b0;
			end
		endcase

		// register zero is never written
		if (widx_n == '0) begin
			wr_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
		end else if (adv && v_s1) begin
			pc_q <= pc_n;
		end
	end

	// data memory: clearing pass, store and load
	always_ff @(posedge clk) begin
		if (clr_q) begin
			dmem[clr_cnt_q] <= '0;
		end else if (adv && v_s1 && mem_acc_n) begin
			if (mwr_n) begin
				dmem[midx_n] <= opb;
			end
			lrd_s2 <= dmem[midx_n];
		end
	end

	// stage 2 capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			wr_s2     <= wr_n;
			widx_s2   <= widx_n;
			val_s2    <= val_n;
			prod_s2   <= prod_n;
			is_mul_s2 <= is_mul_n;
			is_lw_s2  <= is_lw_n;
			taken_s2  <= taken_n;
			mwr_s2    <= mwr_n;
			fault_s2  <= fault_n;
			midx_s2   <= mem_acc_n ? midx_n : '0;
			pc_s2     <= pc_n;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && v_s2) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign midx_ext = 32'(midx_s2);

	always_ff @(posedge clk) begin
		if (adv && v_s2) begin
			pc_out_q <= pc_s2;
			taken_q  <= taken_s2;
			wr_q     <= wr_s2;
			widx_q   <= wr_s2 ? widx_s2 : '0;
			wval_q   <= wr_s2 ? s2_val : '0;
			mwr_q    <= mwr_s2;
			midx_q   <= midx_ext[MemIdxOutW-1:0];
			fault_q  <= fault_s2;
		end
	end

	assign out_valid      = out_valid_q;
	assign next_pc        = pc_out_q;
	assign branch_taken   = taken_q;
	assign reg_written    = wr_q;
	assign written_index  = widx_q;
	assign written_value  = wval_q;
	assign mem_written    = mwr_q;
	assign mem_word_index = midx_q;
	assign address_fault  = fault_q;

endmodule

`default_nettype wire

// ===== design/mse_checker.sv =====
// mse_port_sva: port-level checks on the execute unit's result channel
// depends on mse_pkg; bound to mips_subset_execute_unit at the end of this file
`default_nettype none

module mse_port_sva (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             out_valid,
	input wire logic                             out_ready,
	input wire logic signed [mse_pkg::DataW-1:0] next_pc,
	input wire logic                             branch_taken,
	input wire logic                             reg_written,
	input wire logic [mse_pkg::RegIdxW-1:0]      written_index,
	input wire logic signed [mse_pkg::DataW-1:0] written_value,
	input wire logic                             mem_written,
	input wire logic [mse_pkg::MemIdxOutW-1:0]   mem_word_index,
	input wire logic                             address_fault
);
	import mse_pkg::*;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(next_pc) && $stable(written_value))
		else $error("result changed while stalled");

	// no register write means zero index and value
	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !reg_written |-> written_index == '0 && written_value == '0)
		else $error("stale write-back fields");

	// a faulting access touches nothing
	a_fault_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && address_fault |->
			!mem_written && !reg_written && !branch_taken && mem_word_index == '0)
		else $error("faulting access had side effects");

	// register writes never target register zero and never come with a store
	a_write_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reg_written |-> written_index != '0 && !mem_written)
		else $error("bad register write");

endmodule

bind mips_subset_execute_unit mse_port_sva u_mse_port_sva (.*);

`default_nettype wire
